/* hw/rtl/ppp_ncp_option_automaton_core_defines.svh */
// ----------------------------------------------------------------------------
// PPP NCP option automaton assertion macros
// Shared macros for the concurrent checks on the automaton ports.
// ----------------------------------------------------------------------------
`ifndef PPP_NCP_OPTION_AUTOMATON_CORE_DEFINES_SVH
`define PPP_NCP_OPTION_AUTOMATON_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PNOA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PNOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pnoa_pkg.sv */
// ----------------------------------------------------------------------------
// PPP NCP option automaton package
// Codes, state encoding, sizes and helper functions for the automaton.
// ----------------------------------------------------------------------------
package pnoa_pkg;

  // Width of the retransmit timer.
  localparam int TIMER_WIDTH = 16;
  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

  // Reset values of the configuration registers.
  localparam logic [7:0]  MAX_CONFIGURE_RST = 8'd10;
  localparam logic [7:0]  MAX_TERMINATE_RST = 8'd2;
  localparam logic [7:0]  MAX_NAK_RST       = 8'd5;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd3000;
  localparam logic [7:0]  ID_SEED_RST       = 8'd0;

  // Offset applied to the identifier generator on a collision.
  localparam logic [7:0] IDENT_DODGE = 8'd128;

  // Automaton states.
  typedef enum logic [5:0] {
    ST_INITIAL  = 6'b000001,
    ST_REQ_SENT = 6'b000010,
    ST_ACK_RCVD = 6'b000100,
    ST_ACK_SENT = 6'b001000,
    ST_OPENED   = 6'b010000,
    ST_CLOSING  = 6'b100000
  } state_t;

  // Event codes.
  typedef enum logic [3:0] {
    OP_UP          = 4'd0,
    OP_DOWN        = 4'd1,
    OP_TICK        = 4'd2,
    OP_RCR_GOOD    = 4'd3,
    OP_RCR_BAD     = 4'd4,
    OP_RCR_INVALID = 4'd5,
    OP_RCA         = 4'd6,
    OP_RCN_NAK     = 4'd7,
    OP_RCN_REJECT  = 4'd8,
    OP_RTR         = 4'd9,
    OP_RTA         = 4'd10,
    OP_RXJ_BAD     = 4'd11,
    OP_UNKNOWN     = 4'd12
  } op_t;

  // Link phases carried by a down event.
  typedef enum logic [1:0] {
    LINK_DOWN        = 2'd0,
    LINK_ESTABLISHED = 2'd1
  } link_t;

  // Reply kinds for a bad configure request.
  localparam logic REPLY_NAK = 1'b0;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_MAX_CONFIGURE = 3'd0,
    CFG_MAX_TERMINATE = 3'd1,
    CFG_MAX_NAK       = 3'd2,
    CFG_TIMEOUT_TICKS = 3'd3,
    CFG_SERVER_MODE   = 3'd4,
    CFG_ID_SEED       = 3'd5
  } cfg_idx_t;

  // Nak reply codes.
  typedef enum logic [1:0] {
    NAK_NONE = 2'd0,
    NAK_NAK  = 2'd1,
    NAK_REJ  = 2'd2
  } nak_t;

  // Upper layer report codes.
  typedef enum logic [1:0] {
    LAYER_NONE      = 2'd0,
    LAYER_UP        = 2'd1,
    LAYER_DOWN      = 2'd2,
    LAYER_UP_FAILED = 2'd3
  } layer_t;

  // Phase report codes.
  typedef enum logic [1:0] {
    PHASE_NONE       = 2'd0,
    PHASE_UP_START   = 2'd1,
    PHASE_DOWN_START = 2'd2
  } phase_t;

  // Numeric state code as reported in the result word.
  function automatic logic [2:0] state_code(input state_t s);
    logic [2:0] c;
    c = 3'd0;
    unique case (s)
      ST_INITIAL:  c = 3'd0;
      ST_REQ_SENT: c = 3'd1;
      ST_ACK_RCVD: c = 3'd2;
      ST_ACK_SENT: c = 3'd3;
      ST_OPENED:   c = 3'd4;
      ST_CLOSING:  c = 3'd5;
      default:     c = 3'd0;
    endcase
    return c;
  endfunction

  // Timer load value: zero acts as one and the value is clipped to the timer.
  function automatic logic [TIMER_WIDTH-1:0] arm_value(input logic [15:0] t);
    logic [31:0] w;
    w = {16'd0, t};
    if (w == 32'd0) begin
      w = 32'd1;
    end
    if (w > TIMER_MAX) begin
      w = TIMER_MAX;
    end
    return w[TIMER_WIDTH-1:0];
  endfunction

endpackage

/* hw/rtl/ppp_ncp_option_automaton_core.sv */
// ----------------------------------------------------------------------------
// PPP NCP option negotiation automaton
// Result path: an accepted event word is held in the input register, and its result
// word is written to the result register when that is free or being read. Throughput:
// one event word per cycle while the result channel is not stalled.
// Reset: state returns to initial, counters and timer clear, configuration
// registers take their defaults and the identifier generator loads its seed.
// ----------------------------------------------------------------------------
module ppp_ncp_option_automaton_core
  import pnoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Event channel.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // packet_ident[7:0], link_phase[9:8], reply_kind[10]
  input  logic [3:0]  s_tuser,   // operation[3:0]
  // Result channel.
  output logic        m_tvalid,
  input  logic        m_tready,
  // new_state[2:0], send_conf_request[3], send_conf_ack[4], send_nak_kind[6:5],
  // send_term_request[7], send_term_ack[8], send_code_reject[9],
  // outgoing_ident[17:10], layer_report[19:18], phase_report[21:20],
  // illegal_event[22], ident_mismatch[23]
  output logic [23:0] m_tdata,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic [7:0]  max_configure;
  logic [7:0]  max_terminate;
  logic [7:0]  max_nak;
  logic [15:0] timeout_ticks;
  logic        server_mode;

  // Automaton state.
  state_t                 st;
  logic [7:0]             configure_count;
  logic [7:0]             terminate_count;
  logic [7:0]             nak_count;
  logic [TIMER_WIDTH-1:0] timer_left;
  logic [7:0]             next_ident;
  logic [7:0]             request_ident;
  logic [7:0]             terminate_ident;

  // Input register.
  logic       in_valid;
  op_t        in_op;
  logic [7:0] in_pid;
  logic [1:0] in_phase;
  logic       in_kind;

  logic advance;

  // Decoded actions of the current event.
  state_t nst;
  logic   went;
  logic   do_restart;
  logic   do_zero;
  logic   do_nakdec;
  logic   do_req;
  logic   do_term;
  logic   do_cj;
  logic   do_arm;
  logic   do_dodge;
  logic   tick_dec;
  logic   ack;
  logic   tack;
  logic   ill;
  logic   mis;
  nak_t   nak_kind;
  layer_t layer;
  phase_t phase;

  // Next values of the state.
  logic [7:0]             ni_d;
  logic [7:0]             cc_r;
  logic [7:0]             tc_r;
  logic [7:0]             nc_r;
  logic                   take_id;
  logic [7:0]             out_ident;
  logic [7:0]             configure_count_next;
  logic [7:0]             terminate_count_next;
  logic [7:0]             nak_count_next;
  logic [7:0]             next_ident_next;
  logic [7:0]             request_ident_next;
  logic [7:0]             terminate_ident_next;
  logic [TIMER_WIDTH-1:0] timer_left_next;

  // The held event moves on when the result register is free or being read.
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Transition decode: one arm per event code, then per state.
  always_comb begin
    nst        = st;
    went       = 1'b0;
    do_restart = 1'b0;
    do_zero    = 1'b0;
    do_nakdec  = 1'b0;
    do_req     = 1'b0;
    do_term    = 1'b0;
    do_cj      = 1'b0;
    do_arm     = 1'b0;
    do_dodge   = 1'b0;
    tick_dec   = 1'b0;
    ack        = 1'b0;
    tack       = 1'b0;
    ill        = 1'b0;
    mis        = 1'b0;
    nak_kind   = NAK_NONE;
    layer      = LAYER_NONE;
    unique case (in_op)
      OP_UP: begin
        if (!server_mode && st == ST_INITIAL) begin
          nst = ST_REQ_SENT; went = 1'b1; do_restart = 1'b1; do_req = 1'b1;
        end
      end
      OP_DOWN: begin
        if (in_phase == LINK_DOWN) begin
          nst = ST_INITIAL; went = 1'b1; layer = LAYER_DOWN;
        end else if (in_phase == LINK_ESTABLISHED && st != ST_INITIAL &&
                     st != ST_CLOSING) begin
          nst = ST_CLOSING; went = 1'b1; do_restart = 1'b1; do_term = 1'b1;
        end
      end
      OP_TICK: begin
        if (timer_left != '0) begin
          tick_dec = 1'b1;
          if (timer_left == TIMER_WIDTH'(1)) begin
            unique case (st)
              ST_CLOSING: begin
                if (terminate_count == 8'd0) begin
                  nst = ST_INITIAL; went = 1'b1; layer = LAYER_DOWN;
                end else begin
                  do_term = 1'b1;
                end
              end
              ST_REQ_SENT, ST_ACK_RCVD, ST_ACK_SENT: begin
                if (configure_count == 8'd0) begin
                  nst = ST_INITIAL; went = 1'b1; layer = LAYER_UP_FAILED;
                end else begin
                  if (st == ST_ACK_RCVD) begin
                    nst = ST_REQ_SENT; went = 1'b1;
                  end
                  do_req = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      OP_RCR_GOOD: begin
        do_dodge = 1'b1;
        unique case (st)
          ST_INITIAL: begin
            nst = ST_ACK_SENT; went = 1'b1; do_restart = 1'b1; do_req = 1'b1;
            ack = 1'b1;
          end
          ST_REQ_SENT, ST_ACK_SENT: begin
            nst = ST_ACK_SENT; went = 1'b1; ack = 1'b1;
          end
          ST_ACK_RCVD: begin
            nst = ST_OPENED; went = 1'b1; ack = 1'b1; layer = LAYER_UP;
          end
          ST_OPENED: begin
            nst = ST_ACK_SENT; went = 1'b1; do_req = 1'b1; ack = 1'b1;
          end
          default: ;
        endcase
      end
      OP_RCR_BAD: begin
        do_dodge = 1'b1;
        if (st != ST_CLOSING) begin
          if (st == ST_OPENED) begin
            nst = ST_REQ_SENT; went = 1'b1; do_req = 1'b1;
          end else if (st == ST_ACK_SENT) begin
            nst = ST_REQ_SENT; went = 1'b1;
          end
          if (in_kind == REPLY_NAK && nak_count != 8'd0) begin
            do_nakdec = 1'b1; nak_kind = NAK_NAK;
          end else begin
            nak_kind = NAK_REJ;
          end
        end
      end
      OP_RCR_INVALID: begin
        do_dodge = 1'b1;
        nst = ST_INITIAL; went = 1'b1; layer = LAYER_UP_FAILED;
      end
      OP_RCA: begin
        if (in_pid != request_ident) begin
          mis = 1'b1;
        end else begin
          unique case (st)
            ST_INITIAL: ill = 1'b1;
            ST_REQ_SENT: begin
              nst = ST_ACK_RCVD; went = 1'b1; do_restart = 1'b1;
            end
            ST_ACK_RCVD, ST_OPENED: begin
              nst = ST_REQ_SENT; went = 1'b1; do_req = 1'b1;
            end
            ST_ACK_SENT: begin
              nst = ST_OPENED; went = 1'b1; do_restart = 1'b1; layer = LAYER_UP;
            end
            default: ;
          endcase
        end
      end
      OP_RCN_NAK: begin
        if (in_pid != request_ident) begin
          mis = 1'b1;
        end else begin
          unique case (st)
            ST_INITIAL: ill = 1'b1;
            ST_REQ_SENT, ST_ACK_SENT: begin
              do_restart = 1'b1; do_req = 1'b1;
            end
            ST_ACK_RCVD, ST_OPENED: begin
              nst = ST_REQ_SENT; went = 1'b1; do_req = 1'b1;
            end
            default: ;
          endcase
        end
      end
      OP_RCN_REJECT: begin
        if (in_pid != request_ident) begin
          mis = 1'b1;
        end else begin
          nst = ST_INITIAL; went = 1'b1; layer = LAYER_UP_FAILED;
        end
      end
      OP_RTR: begin
        do_dodge = 1'b1;
        unique case (st)
          ST_INITIAL: ill = 1'b1;
          ST_ACK_RCVD, ST_ACK_SENT: begin
            nst = ST_REQ_SENT; went = 1'b1; tack = 1'b1;
          end
          ST_CLOSING, ST_REQ_SENT: tack = 1'b1;
          ST_OPENED: begin
            nst = ST_CLOSING; went = 1'b1; do_zero = 1'b1; do_arm = 1'b1;
            tack = 1'b1;
          end
          default: ;
        endcase
      end
      OP_RTA: begin
        if (in_pid != terminate_ident) begin
          mis = 1'b1;
        end else begin
          unique case (st)
            ST_INITIAL: ill = 1'b1;
            ST_CLOSING: begin
              nst = ST_INITIAL; went = 1'b1; layer = LAYER_DOWN;
            end
            ST_ACK_RCVD: begin
              nst = ST_REQ_SENT; went = 1'b1;
            end
            ST_OPENED: begin
              nst = ST_REQ_SENT; went = 1'b1; do_req = 1'b1;
            end
            default: ;
          endcase
        end
      end
      OP_RXJ_BAD: begin
        unique case (st)
          ST_INITIAL: ill = 1'b1;
          ST_CLOSING: begin
            nst = ST_INITIAL; went = 1'b1; layer = LAYER_DOWN;
          end
          ST_REQ_SENT, ST_ACK_RCVD, ST_ACK_SENT: begin
            nst = ST_INITIAL; went = 1'b1; layer = LAYER_UP_FAILED;
          end
          ST_OPENED: begin
            nst = ST_CLOSING; went = 1'b1; do_restart = 1'b1; do_term = 1'b1;
          end
          default: ;
        endcase
      end
      OP_UNKNOWN: do_cj = 1'b1;
      default: ;
    endcase
  end

  // Phase report: leaving initial starts the layer, leaving opened stops it.
  always_comb begin
    phase = PHASE_NONE;
    if (went && nst != st) begin
      if (st == ST_INITIAL) begin
        phase = PHASE_UP_START;
      end else if (st == ST_OPENED) begin
        phase = PHASE_DOWN_START;
      end
    end
  end

  // Counter, identifier and timer updates, applied in the order of the protocol.
  always_comb begin
    ni_d = (do_dodge && next_ident == in_pid) ? 8'(next_ident + IDENT_DODGE)
                                               : next_ident;
    cc_r = do_restart ? max_configure : (do_zero ? 8'd0 : configure_count);
    tc_r = do_restart ? max_terminate : (do_zero ? 8'd0 : terminate_count);
    nc_r = do_restart ? max_nak       : (do_zero ? 8'd0 : nak_count);

    configure_count_next = (do_req && cc_r != 8'd0) ? 8'(cc_r - 8'd1) : cc_r;
    terminate_count_next = (do_term && tc_r != 8'd0) ? 8'(tc_r - 8'd1) : tc_r;
    nak_count_next       = do_nakdec ? 8'(nc_r - 8'd1) : nc_r;

    take_id              = do_req || do_term || do_cj;
    out_ident            = take_id ? ni_d : 8'd0;
    next_ident_next      = take_id ? 8'(ni_d + 8'd1) : ni_d;
    request_ident_next   = do_req ? ni_d : request_ident;
    terminate_ident_next = do_term ? ni_d : terminate_ident;

    timer_left_next = tick_dec ? TIMER_WIDTH'(timer_left - TIMER_WIDTH'(1)) : timer_left;
    if (went && (nst == ST_INITIAL || nst == ST_OPENED)) begin
      timer_left_next = '0;
    end
    if (do_req || do_term || do_arm) begin
      timer_left_next = arm_value(timeout_ticks);
    end
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op    <= op_t'(s_tuser);
      in_pid   <= s_tdata[7:0];
      in_phase <= s_tdata[9:8];
      in_kind  <= s_tdata[10];
    end
  end

  // Automaton state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= ST_INITIAL;
      configure_count <= 8'd0;
      terminate_count <= 8'd0;
      nak_count       <= 8'd0;
      timer_left      <= '0;
      next_ident      <= ID_SEED_RST;
      request_ident   <= 8'd0;
      terminate_ident <= 8'd0;
      max_configure   <= MAX_CONFIGURE_RST;
      max_terminate   <= MAX_TERMINATE_RST;
      max_nak         <= MAX_NAK_RST;
      timeout_ticks   <= TIMEOUT_TICKS_RST;
      server_mode     <= 1'b0;
    end else begin
      if (advance) begin
        st              <= nst;
        configure_count <= configure_count_next;
        terminate_count <= terminate_count_next;
        nak_count       <= nak_count_next;
        timer_left      <= timer_left_next;
        next_ident      <= next_ident_next;
        request_ident   <= request_ident_next;
        terminate_ident <= terminate_ident_next;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MAX_CONFIGURE: max_configure <= cfg_data[7:0];
          CFG_MAX_TERMINATE: max_terminate <= cfg_data[7:0];
          CFG_MAX_NAK:       max_nak       <= cfg_data[7:0];
          CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
          CFG_SERVER_MODE:   server_mode   <= cfg_data[0];
          CFG_ID_SEED:       next_ident    <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {mis, ill, phase, layer, out_ident, do_cj, tack, do_term,
                  nak_kind, ack, do_req, state_code(nst)};
    end
  end

endmodule

/* hw/rtl/pnoa_checker.sv */
// ----------------------------------------------------------------------------
// PPP NCP option automaton port checker
// Checks on the result words as seen at the automaton ports.
// ----------------------------------------------------------------------------
`include "ppp_ncp_option_automaton_core_defines.svh"

module pnoa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic [3:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [15:0] cfg_data
);

  logic any_input;
  logic sends_ident;

  // Folded so that every port is observed.
  assign any_input   = (s_tvalid | s_tready | cfg_valid | cfg_ready) ^
                       ((^s_tdata) ^ (^s_tuser) ^ (^cfg_index) ^ (^cfg_data));
  assign sends_ident = m_tdata[3] | m_tdata[7] | m_tdata[9];

  // A stalled result word holds.
  `PNOA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

  // The reported state is always one of the six states.
  `PNOA_ASSERT_NOW(a_state, m_tvalid && (any_input || !any_input), m_tdata[2:0] <= 3'd5, "state code out of range")

  // At most one packet that draws an identifier is sent per event.
  `PNOA_ASSERT_NOW(a_one_id, m_tvalid, ($countones({m_tdata[3], m_tdata[7], m_tdata[9]}) <= 1), "two identifier users in one result")

  // The identifier is zero unless a configure request, a terminate request or a code reject is sent.
  `PNOA_ASSERT_NOW(a_id_zero, m_tvalid && !sends_ident, m_tdata[17:10] == 8'd0, "identifier without a request")

  // A dropped reply causes no action and no report.
  `PNOA_ASSERT_NOW(a_mismatch, m_tvalid && m_tdata[23], m_tdata[22:3] == 20'd0, "action on a mismatched reply")

endmodule

bind ppp_ncp_option_automaton_core pnoa_checker u_pnoa_checker (.*);
